### rtl/fraction_gcd_reducer_top_defines.svh
// Assertion macros shared by the checker
`ifndef FRACTION_GCD_REDUCER_TOP_DEFINES_SVH
`define FRACTION_GCD_REDUCER_TOP_DEFINES_SVH

// Implication checked on every edge outside reset
`define FGR_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FGR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

### rtl/fgr_pkg.sv
package fgr_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StZero     = 2'd1,
    StOverflow = 2'd2
  } status_e;

  // Classification handed from front to back
  typedef struct packed {
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    logic             both_zero;
  } job_t;

  typedef struct packed {
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    status_e          status;
  } res_t;
endpackage

### rtl/fgr_divider.sv
// Signed truncating divider, one quotient bit per cycle
module fgr_divider #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             neg_q_q, neg_q_d, neg_r_q, neg_r_d, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] abs_a, abs_b;

  assign abs_a = dividend_i[WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign abs_b = divisor_i[WIDTH-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dvs_q};

  // Restoring shift-subtract step
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; quo_d = abs_a; dvs_d = abs_b; cnt_d = CntW'(WIDTH);
      neg_q_d = dividend_i[WIDTH-1] ^ divisor_i[WIDTH-1];
      neg_r_d = dividend_i[WIDTH-1]; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[WIDTH]) begin
        rem_d = trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    neg_q_q <= neg_q_d; neg_r_q <= neg_r_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q_q ? (~quo_q + 1'b1) : quo_q;
  assign rem_o  = neg_r_q ? (~rem_q + 1'b1) : rem_q;
endmodule

### rtl/fgr_front.sv
// Input stage: sign-extends operands, flags the both-zero case, holds up to two jobs
module fgr_front #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [2*fgr_pkg::DataW-1:0] data_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output fgr_pkg::job_t       job_o
);
  import fgr_pkg::*;

  localparam int unsigned Depth = 2;

  job_t            fifo_q [Depth];
  logic [1:0]      cnt_q;
  logic            wr_ptr_q, rd_ptr_q;
  logic            push, pop;
  logic [WIDTH-1:0] n_w, d_w;
  job_t            job_in;

  assign n_w = data_i[WIDTH-1:0];
  assign d_w = data_i[DataW+WIDTH-1:DataW];

  // Classify
  always_comb begin
    job_in.num = DataW'($signed(n_w));
    job_in.den = DataW'($signed(d_w));
    job_in.both_zero = (n_w == '0) && (d_w == '0);
  end

  assign ready_o     = (cnt_q != 2'(Depth));
  assign push        = valid_i && ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_ptr_q];

  // Short queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= job_in;
  end
endmodule

### rtl/fgr_back.sv
// Euclid sequencer over one shared divider, with output register
module fgr_back #(
  parameter int unsigned WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  fgr_pkg::job_t job_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output fgr_pkg::res_t res_o
);
  import fgr_pkg::*;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SLoop  = 6'b000010,
    SRem   = 6'b000100,
    SDivN  = 6'b001000,
    SDivD  = 6'b010000,
    SOut   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d, num_q, num_d, den_q, den_d;
  logic [WIDTH-1:0] qn_q, qn_d;
  logic             wrap_q, wrap_d, start;
  logic [WIDTH-1:0] dvd, dvs, quot, rem;
  logic             done;
  logic             out_v_q, out_v_d;
  res_t             out_q, out_d;
  logic [WIDTH-1:0] min_v;

  assign min_v = {1'b1, {(WIDTH-1){1'b0}}};

  fgr_divider #(.WIDTH(WIDTH)) u_div (
    .clk_i, .rst_ni, .start_i(start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(done), .quot_o(quot), .rem_o(rem)
  );

  assign job_ready_o = (state_q == SIdle) && !out_v_q;

  // Sequencer
  always_comb begin
    state_d = state_q; a_d = a_q; b_d = b_q; num_d = num_q; den_d = den_q;
    qn_d = qn_q; wrap_d = wrap_q; start = 1'b0; dvd = b_q; dvs = a_q;
    out_v_d = out_v_q; out_d = out_q;
    if (out_v_q && res_ready_i) out_v_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (job_valid_i && job_ready_o) begin
          num_d = job_i.num[WIDTH-1:0]; den_d = job_i.den[WIDTH-1:0];
          a_d = job_i.num[WIDTH-1:0]; b_d = job_i.den[WIDTH-1:0];
          wrap_d = 1'b0;
          if (job_i.both_zero) begin
            out_d.num = '0; out_d.den = '0; out_d.status = StZero;
            out_v_d = 1'b1;
          end else begin
            state_d = SLoop;
          end
        end
      end
      SLoop: begin
        if (a_q == '0) begin
          state_d = SDivN; start = 1'b1; dvd = num_q; dvs = b_q;
        end else begin
          state_d = SRem; start = 1'b1;
        end
      end
      SRem: begin
        if (done) begin
          a_d = (a_q == '1) ? '0 : rem; b_d = a_q; state_d = SLoop;
        end
      end
      SDivN: begin
        if (done) begin
          qn_d = quot;
          if (b_q == '1 && num_q == min_v) wrap_d = 1'b1;
          state_d = SDivD; start = 1'b1; dvd = den_q; dvs = b_q;
        end
      end
      SDivD: begin
        if (done) begin
          out_d.num = DataW'($signed(qn_q));
          out_d.den = DataW'($signed(quot));
          out_d.status = (wrap_q || (b_q == '1 && den_q == min_v)) ? StOverflow : StOk;
          state_d = SOut;
        end
      end
      SOut: begin
        if (!out_v_q) begin
          out_v_d = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; num_q <= num_d; den_q <= den_d;
    qn_q <= qn_d; wrap_q <= wrap_d; out_q <= out_d;
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
endmodule

### rtl/fraction_gcd_reducer_top.sv
// Fraction reducer by signed Euclid divisor.
// Input channel s_axis: tdata carries numerator (bits 63:0) and denominator
// (bits 127:64), each read as a WIDTH-bit signed value in its low bits.
// Output channel m_axis: tdata carries numerator_out (63:0), denominator_out
// (127:64) and status (129:128), padded with zeros to 136 bits.
// Status: 0 ok, 1 both inputs zero, 2 quotient wrapped.
// Each Euclid step is one division in the shared bit-serial divider, and
// two final divisions follow. Both-zero inputs skip the divider.
// Throughput: one item at a time in the back end; a two-entry queue in the
// front takes further transfers meanwhile.
// Reset empties the queue and drops any result in flight.
// A stalled receiver holds the result in the output register; the back
// end then waits, and the input side stalls once the queue is full.
module fraction_gcd_reducer_top #(
  parameter int unsigned WIDTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // numerator_in, denominator_in
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // numerator_out, denominator_out, status
);
  import fgr_pkg::*;

  logic  job_valid, job_ready;
  job_t  job;
  res_t  res;

  fgr_front #(.WIDTH(WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .data_i(s_axis_tdata), .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_o(job)
  );

  fgr_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {6'b0, res.status, res.den, res.num};
endmodule

### rtl/fgr_checker.sv
`include "fraction_gcd_reducer_top_defines.svh"
// Port-level checks on the reducer
module fgr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  import fgr_pkg::*;

  `FGR_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `FGR_ASSERT_IMP(a_status, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[129:128] <= StOverflow)
  `FGR_ASSERT_IMP(a_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[129:128] == StZero, m_axis_tdata[127:0] == '0)
  `FGR_ASSERT_NEXT(a_noburst, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind fraction_gcd_reducer_top fgr_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### tb/sv/fraction_gcd_reducer_top_tb.sv
module fraction_gcd_reducer_top_tb;
  import fgr_pkg::*;

  // Expected reductions, oldest first
  class reduction_scoreboard;
    res_t pending_q[$];
    int   n_errors;
    int   n_checked;
    int   n_zero;
    int   n_wrap;

    // Truncating quotient; a divisor of -1 negates and may wrap
    function automatic longint quot(longint x, longint d, ref bit wrapped);
      longint r;
      if (d == -1) begin
        r = -x;
        if (x != 0 && r == x) wrapped = 1'b1;
        return r;
      end
      return x / d;
    endfunction

    // Work out the reduced fraction for one accepted transfer
    function void note_input(logic [63:0] num_raw, logic [63:0] den_raw);
      longint num, den, a, b, prev;
      bit     wrapped;
      res_t   exp_res;
      num = num_raw;
      den = den_raw;
      wrapped = 1'b0;
      if (num == 0 && den == 0) begin
        exp_res.num = '0;
        exp_res.den = '0;
        exp_res.status = StZero;
      end else begin
        a = num;
        b = den;
        // Euclid with truncating remainder; rem by -1 is zero
        while (a != 0) begin
          prev = a;
          a = (a == -1) ? 0 : b % a;
          b = prev;
        end
        exp_res.num = quot(num, b, wrapped);
        exp_res.den = quot(den, b, wrapped);
        exp_res.status = wrapped ? StOverflow : StOk;
      end
      pending_q.push_back(exp_res);
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_result(logic [135:0] data);
      res_t exp_res;
      logic [63:0] act_num, act_den;
      logic [1:0]  act_st;
      act_num = data[63:0];
      act_den = data[127:64];
      act_st  = data[129:128];
      if (pending_q.size() == 0) begin
        $error("unexpected result num=%0d den=%0d status=%0d",
               $signed(act_num), $signed(act_den), act_st);
        n_errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      n_checked++;
      if (exp_res.status == StZero) n_zero++;
      if (exp_res.status == StOverflow) n_wrap++;
      if (act_num !== exp_res.num) begin
        $error("numerator_out expected %0d actual %0d", $signed(exp_res.num),
               $signed(act_num));
        n_errors++;
      end
      if (act_den !== exp_res.den) begin
        $error("denominator_out expected %0d actual %0d", $signed(exp_res.den),
               $signed(act_den));
        n_errors++;
      end
      if (act_st !== exp_res.status) begin
        $error("status expected %0d actual %0d", exp_res.status, act_st);
        n_errors++;
      end
    endfunction
  endclass

  localparam longint MinVal = 64'sh8000_0000_0000_0000;
  localparam longint MaxVal = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  reduction_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;
  int n_sent;

  fraction_gcd_reducer_top #(
    .WIDTH(64)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver readiness
  always @(posedge clk_i) begin
    if (!rst_ni || recv_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tdata[63:0], s_axis_tdata[127:64]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // Offer one fraction and wait for its transfer
  task automatic send_fraction(longint num, longint den);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {den, num};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Random fraction: full range, shared factors, small values or Fibonacci pairs
  task automatic send_random();
    longint num, den, k, fa, fb, t;
    int sel, steps;
    sel = $urandom_range(99);
    if (sel < 40) begin
      num = {$urandom(), $urandom()};
      den = {$urandom(), $urandom()};
    end else if (sel < 70) begin
      k = $signed({$urandom(), $urandom()}) >>> $urandom_range(63, 20);
      num = k * $signed($urandom_range(2000) - 1000);
      den = k * $signed($urandom_range(2000) - 1000);
    end else if (sel < 95) begin
      num = $signed($urandom_range(64)) - 32;
      den = $signed($urandom_range(64)) - 32;
    end else begin
      fa = 1;
      fb = 1;
      steps = $urandom_range(90, 10);
      repeat (steps) begin
        t = fa + fb;
        fa = fb;
        fb = t;
      end
      num = $urandom_range(1) ? fa : -fa;
      den = $urandom_range(1) ? fb : -fb;
    end
    send_fraction(num, den);
  endtask

  // Stimulus
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold     = 1'b0;
    n_sent        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners
    send_fraction(0, 0);
    send_fraction(0, 5);
    send_fraction(0, -7);
    send_fraction(7, 0);
    send_fraction(-9, 0);
    send_fraction(MinVal, -1);
    send_fraction(-1, MinVal);
    send_fraction(MinVal, MinVal);
    send_fraction(MaxVal, MinVal);
    send_fraction(MaxVal, -1);
    send_fraction(MinVal, 1);
    send_fraction(MinVal, 0);
    send_fraction(0, MinVal);
    send_fraction(6, -4);
    send_fraction(-6, 4);
    send_fraction(-12, -18);
    send_fraction(1, 1);
    send_fraction(-1, -1);
    send_fraction(MaxVal, MaxVal);
    send_fraction(MinVal, 2);
    send_fraction(-64'sd1, -64'sd2);
    send_fraction(64'sd7540113804746346429, 64'sd4660046610375530309);

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (70) send_random();
    end

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      repeat (8) send_random();
      begin
        recv_hold = 1'b1;
        repeat (40000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join
    s_axis_tvalid <= 1'b0;

    // Drain
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d fractions, checked %0d results (%0d both-zero, %0d wrapped)",
             n_sent, sb.n_checked, sb.n_zero, sb.n_wrap);
    $display("Covered no-idle, sender-idle, receiver-stall, mixed and hold-off phases");
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/fgr_pkg.sv
rtl/fgr_divider.sv
rtl/fgr_front.sv
rtl/fgr_back.sv
rtl/fraction_gcd_reducer_top.sv
rtl/fgr_checker.sv
tb/sv/fraction_gcd_reducer_top_tb.sv
